// ===== src/impact_freefall_landing_detector_top_macros.svh =====
// assertion macros shared by the impact and freefall detector rtl
`ifndef IMPACT_FREEFALL_LANDING_DETECTOR_TOP_MACROS_SVH
`define IMPACT_FREEFALL_LANDING_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IFLD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define IFLD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ifld_pkg.sv =====
// types and constants for the impact and freefall detector
package ifld_pkg;

   // field widths
   localparam int ACCEL_W = 15;
   localparam int SQ1_W   = 29;
   localparam int MSQ_W   = 30;
   localparam int TIME_W  = 32;
   localparam int THR_W   = 14;
   localparam int THR_SQ_W = 28;
   localparam int HOLD_W  = 16;
   localparam int CNT_W   = 32;
   localparam int LVL_W   = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 168;

   // timing constants in milliseconds
   localparam logic [TIME_W-1:0] IMPACT_DEBOUNCE_MS = 32'd400;
   localparam logic [TIME_W-1:0] FLIGHT_TIMEOUT_MS  = 32'd3000;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_HARD_IMPACT     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MODERATE_IMPACT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_IMPACT    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FREEFALL        = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FREEFALL_HOLD   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LANDING         = 3'd5;

   // register reset values
   localparam logic [THR_W-1:0]  HARD_IMPACT_RST     = 14'd4000;
   localparam logic [THR_W-1:0]  MODERATE_IMPACT_RST = 14'd2500;
   localparam logic [THR_W-1:0]  LIGHT_IMPACT_RST    = 14'd1500;
   localparam logic [THR_W-1:0]  FREEFALL_RST        = 14'd300;
   localparam logic [HOLD_W-1:0] FREEFALL_HOLD_RST   = 16'd150;
   localparam logic [THR_W-1:0]  LANDING_RST         = 14'd2000;

   // impact levels
   localparam logic [LVL_W-1:0] LVL_NONE     = 2'd0;
   localparam logic [LVL_W-1:0] LVL_LIGHT    = 2'd1;
   localparam logic [LVL_W-1:0] LVL_MODERATE = 2'd2;
   localparam logic [LVL_W-1:0] LVL_HARD     = 2'd3;

   // event codes of a result word
   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_LIGHT       = 3'd1,
      EV_MODERATE    = 3'd2,
      EV_HARD        = 3'd3,
      EV_FREEFALL    = 3'd4,
      EV_LAND_SMOOTH = 3'd5,
      EV_LAND_HARD   = 3'd6
   } event_type;

   // fields shared by every word of one sample
   typedef struct packed {
      logic [MSQ_W-1:0]  magnitude_sq;
      logic [TIME_W-1:0] event_time_ms;
      logic              airborne_now;
      logic [LVL_W-1:0]  last_impact_level;
      logic [CNT_W-1:0]  hard_impact_count;
      logic [CNT_W-1:0]  strong_impact_count;
      logic [TIME_W-1:0] flight_time_ms;
   } rsp_rec_type;

endpackage

// ===== src/impact_freefall_landing_detector_top.sv =====
// impact, freefall and landing detector for three-axis accelerometer samples
// the first result word comes from the result register, after stages s1 to s4
// throughput: one sample per cycle while rsp_tready holds and it yields one result word,
//   two-word samples stall the next; set by the single result register, one word a cycle
// reset: synchronous, clears pipeline valids, flight and impact state and counters,
//   and loads the default thresholds
`include "impact_freefall_landing_detector_top_macros.svh"

module impact_freefall_landing_detector_top import ifld_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // accel_x[14:0], accel_y[29:15], accel_z[44:30], time_ms[76:45], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // sample_valid[0]
   input  logic                  req_tuser,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // event_res[2:0], magnitude_sq[32:3], event_time_ms[64:33], airborne_now[65],
   // last_impact_level[67:66], hard_impact_count[99:68],
   // strong_impact_count[131:100], flight_time_ms[163:132], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // threshold registers
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // threshold registers and their squares
   logic [THR_W-1:0]    hard_thr_ff, mod_thr_ff, light_thr_ff, ff_thr_ff, land_thr_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic [THR_SQ_W-1:0] hard_sq_ff, mod_sq_ff, light_sq_ff, ff_sq_ff, land_sq_ff;

   // pipeline stages
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                     s1_ok_ff, s2_ok_ff, s3_ok_ff, s4_ok_ff;
   logic [TIME_W-1:0]        s1_time_ff, s2_time_ff, s3_time_ff, s4_time_ff;
   logic signed [ACCEL_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [2*ACCEL_W-1:0] x_prod, y_prod, z_prod;
   logic [SQ1_W-1:0]         s2_xsq_ff, s2_ysq_ff, s2_zsq_ff;
   logic [MSQ_W-1:0]         s3_msq_ff, s4_msq_ff;
   logic                     s4_ge_hard_ff, s4_ge_mod_ff, s4_ge_light_ff;
   logic                     s4_lt_ff_ff, s4_gt_land_ff;
   logic                     adv1, adv2, adv3, adv4, load_out;

   // detector state
   logic              air_ff, air_in;
   logic [TIME_W-1:0] flight_start_ff, flight_start_in;
   logic              lowg_timing_ff, lowg_timing_in;
   logic [TIME_W-1:0] lowg_start_ff, lowg_start_in;
   logic [TIME_W-1:0] last_imp_ff, last_imp_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [CNT_W-1:0]  hard_cnt_ff, hard_cnt_in;
   logic [CNT_W-1:0]  strong_cnt_ff, strong_cnt_in;
   logic [TIME_W-1:0] airtime_ff, airtime_in;

   // result register
   logic        out_valid_ff, out_sel_ff, out_two_ff, out_two_in;
   event_type   out_ev0_ff, out_ev1_ff, out_ev0_in, out_ev1_in;
   rsp_rec_type out_rec_ff, out_rec_in;
   event_type   cur_ev;

   // decision temporaries
   logic [TIME_W-1:0] imp_gap, lowg_start_eff, lowg_gap, flight_gap;
   logic              has_imp, has_second;
   event_type         imp_ev, second_ev;

   // threshold register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hard_thr_ff  <= HARD_IMPACT_RST;
         mod_thr_ff   <= MODERATE_IMPACT_RST;
         light_thr_ff <= LIGHT_IMPACT_RST;
         ff_thr_ff    <= FREEFALL_RST;
         hold_ff      <= FREEFALL_HOLD_RST;
         land_thr_ff  <= LANDING_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_HARD_IMPACT:     hard_thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_MODERATE_IMPACT: mod_thr_ff   <= csr_wdata[THR_W-1:0];
            CSR_LIGHT_IMPACT:    light_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_FREEFALL:        ff_thr_ff    <= csr_wdata[THR_W-1:0];
            CSR_FREEFALL_HOLD:   hold_ff      <= csr_wdata[HOLD_W-1:0];
            CSR_LANDING:         land_thr_ff  <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // squared thresholds, registered from the threshold registers
   always_ff @(posedge clock) begin
      hard_sq_ff  <= THR_SQ_W'(hard_thr_ff) * THR_SQ_W'(hard_thr_ff);
      mod_sq_ff   <= THR_SQ_W'(mod_thr_ff) * THR_SQ_W'(mod_thr_ff);
      light_sq_ff <= THR_SQ_W'(light_thr_ff) * THR_SQ_W'(light_thr_ff);
      ff_sq_ff    <= THR_SQ_W'(ff_thr_ff) * THR_SQ_W'(ff_thr_ff);
      land_sq_ff  <= THR_SQ_W'(land_thr_ff) * THR_SQ_W'(land_thr_ff);
   end

   // stage advance, bubbles collapse toward the result register
   assign load_out   = s4_valid_ff && (!out_valid_ff || (rsp_tready && rsp_tlast));
   assign adv4       = !s4_valid_ff || load_out;
   assign adv3       = !s3_valid_ff || adv4;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;

   // per-axis squares
   assign x_prod = (2*ACCEL_W)'(s1_x_ff) * (2*ACCEL_W)'(s1_x_ff);
   assign y_prod = (2*ACCEL_W)'(s1_y_ff) * (2*ACCEL_W)'(s1_y_ff);
   assign z_prod = (2*ACCEL_W)'(s1_z_ff) * (2*ACCEL_W)'(s1_z_ff);

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_tvalid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // pipeline payload: capture, square, sum, compare
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ok_ff   <= req_tuser;
         s1_x_ff    <= req_tdata[14:0];
         s1_y_ff    <= req_tdata[29:15];
         s1_z_ff    <= req_tdata[44:30];
         s1_time_ff <= req_tdata[76:45];
      end
      if (adv2) begin
         s2_ok_ff   <= s1_ok_ff;
         s2_time_ff <= s1_time_ff;
         s2_xsq_ff  <= x_prod[SQ1_W-1:0];
         s2_ysq_ff  <= y_prod[SQ1_W-1:0];
         s2_zsq_ff  <= z_prod[SQ1_W-1:0];
      end
      if (adv3) begin
         s3_ok_ff   <= s2_ok_ff;
         s3_time_ff <= s2_time_ff;
         s3_msq_ff  <= s2_ok_ff ? (MSQ_W'(s2_xsq_ff) + MSQ_W'(s2_ysq_ff) + MSQ_W'(s2_zsq_ff))
                                : '0;
      end
      if (adv4) begin
         s4_ok_ff       <= s3_ok_ff;
         s4_time_ff     <= s3_time_ff;
         s4_msq_ff      <= s3_msq_ff;
         s4_ge_hard_ff  <= s3_msq_ff >= MSQ_W'(hard_sq_ff);
         s4_ge_mod_ff   <= s3_msq_ff >= MSQ_W'(mod_sq_ff);
         s4_ge_light_ff <= s3_msq_ff >= MSQ_W'(light_sq_ff);
         s4_lt_ff_ff    <= s3_msq_ff <  MSQ_W'(ff_sq_ff);
         s4_gt_land_ff  <= s3_msq_ff >  MSQ_W'(land_sq_ff);
      end
   end

   // time gaps, all modulo 2^32
   assign imp_gap        = s4_time_ff - last_imp_ff;
   assign lowg_start_eff = lowg_timing_ff ? lowg_start_ff : s4_time_ff;
   assign lowg_gap       = s4_time_ff - lowg_start_eff;
   assign flight_gap     = s4_time_ff - flight_start_ff;

   // impact, freefall and landing decision, next state
   always_comb begin
      air_in          = air_ff;
      flight_start_in = flight_start_ff;
      lowg_timing_in  = lowg_timing_ff;
      lowg_start_in   = lowg_start_ff;
      last_imp_in     = last_imp_ff;
      level_in        = level_ff;
      hard_cnt_in     = hard_cnt_ff;
      strong_cnt_in   = strong_cnt_ff;
      airtime_in      = airtime_ff;
      has_imp         = 1'b0;
      imp_ev          = EV_NONE;
      has_second      = 1'b0;
      second_ev       = EV_NONE;

      if (s4_ok_ff) begin
         // impact class with debounce, light ignored while airborne
         if (imp_gap >= IMPACT_DEBOUNCE_MS) begin
            if (s4_ge_hard_ff) begin
               has_imp       = 1'b1;
               imp_ev        = EV_HARD;
               level_in      = LVL_HARD;
               last_imp_in   = s4_time_ff;
               strong_cnt_in = strong_cnt_ff + CNT_W'(1);
               hard_cnt_in   = hard_cnt_ff + CNT_W'(1);
            end else if (s4_ge_mod_ff) begin
               has_imp       = 1'b1;
               imp_ev        = EV_MODERATE;
               level_in      = LVL_MODERATE;
               last_imp_in   = s4_time_ff;
               strong_cnt_in = strong_cnt_ff + CNT_W'(1);
            end else if (s4_ge_light_ff && !air_ff) begin
               has_imp     = 1'b1;
               imp_ev      = EV_LIGHT;
               level_in    = LVL_LIGHT;
               last_imp_in = s4_time_ff;
            end
         end
         if (!air_ff) begin
            // low-g timer toward freefall
            if (s4_lt_ff_ff) begin
               if (lowg_gap >= TIME_W'(hold_ff)) begin
                  has_second      = 1'b1;
                  second_ev       = EV_FREEFALL;
                  air_in          = 1'b1;
                  flight_start_in = s4_time_ff;
                  lowg_timing_in  = 1'b0;
               end else begin
                  lowg_timing_in = 1'b1;
                  lowg_start_in  = lowg_start_eff;
               end
            end else begin
               lowg_timing_in = 1'b0;
            end
         end else if (s4_gt_land_ff) begin
            // landing spike
            has_second = 1'b1;
            second_ev  = s4_ge_mod_ff ? EV_LAND_HARD : EV_LAND_SMOOTH;
            air_in     = 1'b0;
            airtime_in = flight_gap;
         end else if (flight_gap > FLIGHT_TIMEOUT_MS) begin
            has_second = 1'b1;
            second_ev  = EV_LAND_SMOOTH;
            air_in     = 1'b0;
            airtime_in = flight_gap;
         end
      end else if (air_ff && (flight_gap > FLIGHT_TIMEOUT_MS)) begin
         // missing sample only ends a flight by timeout
         has_second = 1'b1;
         second_ev  = EV_LAND_SMOOTH;
         air_in     = 1'b0;
      end

      // word order: impact first, then freefall or landing
      out_ev0_in = has_imp ? imp_ev : second_ev;
      out_ev1_in = second_ev;
      out_two_in = has_imp && has_second;

      out_rec_in.magnitude_sq        = s4_msq_ff;
      out_rec_in.event_time_ms       = s4_time_ff;
      out_rec_in.airborne_now        = air_in;
      out_rec_in.last_impact_level   = level_in;
      out_rec_in.hard_impact_count   = hard_cnt_in;
      out_rec_in.strong_impact_count = strong_cnt_in;
      out_rec_in.flight_time_ms      = airtime_in;
   end

   // detector state update
   always_ff @(posedge clock) begin
      if (reset) begin
         air_ff          <= 1'b0;
         flight_start_ff <= '0;
         lowg_timing_ff  <= 1'b0;
         lowg_start_ff   <= '0;
         last_imp_ff     <= '0;
         level_ff        <= LVL_NONE;
         hard_cnt_ff     <= '0;
         strong_cnt_ff   <= '0;
         airtime_ff      <= '0;
      end else if (load_out) begin
         air_ff          <= air_in;
         flight_start_ff <= flight_start_in;
         lowg_timing_ff  <= lowg_timing_in;
         lowg_start_ff   <= lowg_start_in;
         last_imp_ff     <= last_imp_in;
         level_ff        <= level_in;
         hard_cnt_ff     <= hard_cnt_in;
         strong_cnt_ff   <= strong_cnt_in;
         airtime_ff      <= airtime_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_sel_ff   <= 1'b0;
         out_two_ff   <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
         out_sel_ff   <= 1'b0;
         out_two_ff   <= out_two_in;
      end else if (rsp_tvalid && rsp_tready) begin
         if (rsp_tlast) begin
            out_valid_ff <= 1'b0;
            out_sel_ff   <= 1'b0;
         end else begin
            out_sel_ff <= 1'b1;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ev0_ff <= out_ev0_in;
         out_ev1_ff <= out_ev1_in;
         out_rec_ff <= out_rec_in;
      end
   end

   // result word
   assign cur_ev     = out_sel_ff ? out_ev1_ff : out_ev0_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = !out_two_ff || out_sel_ff;
   assign rsp_tdata  = {4'b0000,
                        out_rec_ff.flight_time_ms,
                        out_rec_ff.strong_impact_count,
                        out_rec_ff.hard_impact_count,
                        out_rec_ff.last_impact_level,
                        out_rec_ff.airborne_now,
                        out_rec_ff.event_time_ms,
                        out_rec_ff.magnitude_sq,
                        cur_ev};

   // checks
   `IFLD_ASSERT_IMPLIES(a_second_word_shape, clock, reset, out_sel_ff,
      out_valid_ff && out_two_ff, "second word shown without a two-word sample")
   `IFLD_ASSERT_IMPLIES(a_second_event_kind, clock, reset, out_valid_ff && out_two_ff,
      (out_ev1_ff == EV_FREEFALL) || (out_ev1_ff == EV_LAND_SMOOTH) ||
      (out_ev1_ff == EV_LAND_HARD), "second word is not a flight event")
   `IFLD_ASSERT_IMPLIES(a_hard_tracks_strong, clock, reset,
      hard_cnt_ff != $past(hard_cnt_ff), strong_cnt_ff != $past(strong_cnt_ff),
      "hard count moved without strong count")
   `IFLD_ASSERT_NEXT(a_first_word_moves_on, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast, out_valid_ff && out_sel_ff,
      "second word lost after first word taken")
   `IFLD_ASSERT_IMPLIES(a_freefall_sets_airborne, clock, reset,
      out_valid_ff && (cur_ev == EV_FREEFALL), out_rec_ff.airborne_now,
      "freefall reported while not airborne")

endmodule

// ===== verif/impact_freefall_landing_detector_top_tb.sv =====
// self-checking testbench for the impact, freefall and landing detector
`timescale 1ns / 1ps

module impact_freefall_landing_detector_top_tb import ifld_pkg::*;;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int NUM_ROWS       = 26;
   localparam int NUM_REGS       = 6;

   // one expected result word
   typedef struct {
      event_type         ev;
      bit [MSQ_W-1:0]    msq;
      bit [TIME_W-1:0]   stamp;
      bit                air;
      bit [LVL_W-1:0]    lvl;
      bit [CNT_W-1:0]    hard;
      bit [CNT_W-1:0]    heavy;
      bit [TIME_W-1:0]   airtime;
      bit                last;
   } event_word_type;

   // one directed sample, with the first event typed in where it is obvious
   typedef struct packed {
      bit              ok;
      int              x;
      int              y;
      int              z;
      bit [TIME_W-1:0] stamp;
      bit              typed;
      event_type       first_ev;
   } sample_row_type;

   localparam logic [CSR_ADDR_W-1:0] REG_ORDER [NUM_REGS] = '{
      CSR_HARD_IMPACT, CSR_MODERATE_IMPACT, CSR_LIGHT_IMPACT,
      CSR_FREEFALL, CSR_FREEFALL_HOLD, CSR_LANDING
   };

   // walk through debounce, every impact class, freefall, both landings,
   // the flight timeout on valid and invalid samples, extremes and time wrap
   localparam sample_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{1'b1,   5000,     0,      0, 32'd100,       1'b1, EV_NONE},
      '{1'b1,   4000,     0,      0, 32'd500,       1'b1, EV_HARD},
      '{1'b1,   2500,     0,      0, 32'd900,       1'b1, EV_MODERATE},
      '{1'b1,   2000,     0,      0, 32'd1299,      1'b1, EV_NONE},
      '{1'b1,   1500,     0,      0, 32'd1300,      1'b1, EV_LIGHT},
      '{1'b0, -16384, 16383,     -1, 32'd1400,      1'b1, EV_NONE},
      '{1'b1,      0,     0,      0, 32'd2000,      1'b0, EV_NONE},
      '{1'b1,      0,     0,    100, 32'd2149,      1'b0, EV_NONE},
      '{1'b1,      0,     0,      0, 32'd2150,      1'b1, EV_FREEFALL},
      '{1'b1,   1800,     0,      0, 32'd2200,      1'b0, EV_NONE},
      '{1'b1,   2200,     0,      0, 32'd2300,      1'b1, EV_LAND_SMOOTH},
      '{1'b1,      0,     0,      0, 32'd3000,      1'b0, EV_NONE},
      '{1'b1,      0,     0,      0, 32'd3200,      1'b0, EV_NONE},
      '{1'b1,   3000,     0,      0, 32'd3700,      1'b1, EV_MODERATE},
      '{1'b1,      0,     0,      0, 32'd4000,      1'b0, EV_NONE},
      '{1'b1,      0,     0,      0, 32'd4150,      1'b0, EV_NONE},
      '{1'b0,      0,     0,      0, 32'd7150,      1'b0, EV_NONE},
      '{1'b0,      0,     0,      0, 32'd7151,      1'b1, EV_LAND_SMOOTH},
      '{1'b1,      0,     0,      0, 32'd8000,      1'b0, EV_NONE},
      '{1'b1,      0,     0,      0, 32'd8150,      1'b0, EV_NONE},
      '{1'b1,    100,     0,      0, 32'd11151,     1'b1, EV_LAND_SMOOTH},
      '{1'b1, -16384,-16384, -16384, 32'd11600,     1'b1, EV_HARD},
      '{1'b1,  16383, 16383,  16383, 32'd12000,     1'b1, EV_HARD},
      '{1'b1,      0,     0,      0, 32'hFFFF_FFF0, 1'b0, EV_NONE},
      '{1'b1,      0,     0,      0, 32'h0000_0080, 1'b0, EV_NONE},
      '{1'b1,      0,     0,      0, 32'h0000_00A0, 1'b0, EV_NONE}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // detector state as predicted
   bit [THR_W-1:0]  thr_hard, thr_mod, thr_light, thr_ff, thr_land;
   bit [HOLD_W-1:0] hold_ms;
   bit              m_airborne, m_lowg_on;
   bit [TIME_W-1:0] m_flight_start, m_lowg_start, m_last_impact, m_airtime;
   bit [LVL_W-1:0]  m_level;
   bit [CNT_W-1:0]  m_hard, m_strong;

   event_word_type  event_words_due [$];
   bit [TIME_W-1:0] sensor_ms;
   bit              idle_on = 1'b1;
   int              errors = 0;
   int              samples_sent = 0;
   int              words_checked = 0;
   int              settings_used = 1;
   int              ev_seen [7];
   int              stall_left = 0;
   int              quiet_cycles = 0;

   impact_freefall_landing_detector_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sq(bit [THR_W-1:0] v);
      return longint'(v) * longint'(v);
   endfunction

   // advance the predicted detector by one sample and queue its result words
   function automatic int classify_sample(bit ok, bit signed [ACCEL_W-1:0] ax,
                                          bit signed [ACCEL_W-1:0] ay,
                                          bit signed [ACCEL_W-1:0] az,
                                          bit [TIME_W-1:0] now);
      longint         msq;
      bit             was_air;
      event_type      evs [$];
      event_word_type w;
      msq = 0;
      if (ok) begin
         msq = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
             + longint'(az) * longint'(az);
         was_air = m_airborne;
         // impact class, held off inside the debounce window
         if (now - m_last_impact >= IMPACT_DEBOUNCE_MS) begin
            if (msq >= sq(thr_hard)) begin
               m_level = LVL_HARD;
               m_last_impact = now;
               m_strong++;
               m_hard++;
               evs.push_back(EV_HARD);
            end else if (msq >= sq(thr_mod)) begin
               m_level = LVL_MODERATE;
               m_last_impact = now;
               m_strong++;
               evs.push_back(EV_MODERATE);
            end else if (msq >= sq(thr_light) && !was_air) begin
               m_level = LVL_LIGHT;
               m_last_impact = now;
               evs.push_back(EV_LIGHT);
            end
         end
         // freefall timing on the ground, landing or timeout in the air
         if (!m_airborne) begin
            if (msq < sq(thr_ff)) begin
               if (!m_lowg_on) begin
                  m_lowg_on = 1'b1;
                  m_lowg_start = now;
               end
               if (now - m_lowg_start >= hold_ms) begin
                  m_airborne = 1'b1;
                  m_flight_start = now;
                  m_lowg_on = 1'b0;
                  evs.push_back(EV_FREEFALL);
               end
            end else begin
               m_lowg_on = 1'b0;
            end
         end else if (msq > sq(thr_land)) begin
            m_airtime = now - m_flight_start;
            m_airborne = 1'b0;
            if (msq >= sq(thr_mod))
               evs.push_back(EV_LAND_HARD);
            else
               evs.push_back(EV_LAND_SMOOTH);
         end else if (now - m_flight_start > FLIGHT_TIMEOUT_MS) begin
            m_airtime = now - m_flight_start;
            m_airborne = 1'b0;
            evs.push_back(EV_LAND_SMOOTH);
         end
      end else if (m_airborne && now - m_flight_start > FLIGHT_TIMEOUT_MS) begin
         // missing sample only ends a flight by timeout, airtime kept
         m_airborne = 1'b0;
         evs.push_back(EV_LAND_SMOOTH);
      end
      if (evs.size() == 0)
         evs.push_back(EV_NONE);
      foreach (evs[k]) begin
         w.ev = evs[k];
         w.msq = msq[MSQ_W-1:0];
         w.stamp = now;
         w.air = m_airborne;
         w.lvl = m_level;
         w.hard = m_hard;
         w.heavy = m_strong;
         w.airtime = m_airtime;
         w.last = (k == evs.size() - 1);
         event_words_due.push_back(w);
      end
      return evs.size();
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // send one sample word, with an occasional gap before it
   task automatic send_sample(bit ok, int ax, int ay, int az, bit [TIME_W-1:0] now,
                              output int n);
      bit signed [ACCEL_W-1:0] sx, sy, sz;
      int gap;
      sx = ACCEL_W'(ax);
      sy = ACCEL_W'(ay);
      sz = ACCEL_W'(az);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= ok;
      req_tdata <= {3'b000, now, sz, sy, sx};
      do @(posedge clock); while (!req_tready);
      n = classify_sample(ok, sx, sy, sz, now);
      samples_sent++;
   endtask

   // stop sending and let every outstanding word come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (event_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all six threshold registers while the detector is idle
   task automatic load_thresholds(bit [15:0] h, bit [15:0] m, bit [15:0] l,
                                  bit [15:0] f, bit [15:0] hold, bit [15:0] land);
      bit [CSR_DATA_W-1:0] vals [NUM_REGS];
      vals = '{h, m, l, f, hold, land};
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we <= 1'b1;
         csr_addr <= REG_ORDER[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      thr_hard = h[THR_W-1:0];
      thr_mod = m[THR_W-1:0];
      thr_light = l[THR_W-1:0];
      thr_ff = f[THR_W-1:0];
      hold_ms = hold;
      thr_land = land[THR_W-1:0];
      settings_used++;
   endtask

   // random motion: runs of quiet, near-threshold, moderate and wild samples
   task automatic random_samples(int count);
      int run_left, mode, step, lim, n;
      int ax, ay, az;
      bit ok;
      run_left = 0;
      mode = 0;
      for (int k = 0; k < count; k++) begin
         if (run_left == 0) begin
            mode = $urandom_range(0, 9);
            run_left = $urandom_range(1, 10);
         end
         run_left--;
         step = $urandom_range(0, 39);
         if (step < 26)
            sensor_ms += $urandom_range(1, 60);
         else if (step < 35)
            sensor_ms += $urandom_range(60, 700);
         else if (step < 39)
            sensor_ms += $urandom_range(2800, 3300);
         else
            sensor_ms = $urandom;
         ok = ($urandom_range(0, 11) != 0);
         if (mode < 4) begin
            // every axis within half the freefall level
            lim = int'(thr_ff) / 2;
            ax = int'($urandom_range(0, 2 * lim)) - lim;
            ay = int'($urandom_range(0, 2 * lim)) - lim;
            az = int'($urandom_range(0, 2 * lim)) - lim;
         end else if (mode < 6) begin
            // a single axis right at one of the thresholds
            case ($urandom_range(0, 4))
               0: lim = int'(thr_hard);
               1: lim = int'(thr_mod);
               2: lim = int'(thr_light);
               3: lim = int'(thr_ff);
               default: lim = int'(thr_land);
            endcase
            lim = lim + int'($urandom_range(0, 4)) - 2;
            if (lim > 16383) lim = 16383;
            if (lim < 0) lim = 0;
            ax = $urandom_range(0, 1) ? -lim : lim;
            ay = 0;
            az = 0;
            if ($urandom_range(0, 1)) begin
               az = ax;
               ax = 0;
            end
         end else if (mode < 8) begin
            ax = int'($urandom_range(0, 8000)) - 4000;
            ay = int'($urandom_range(0, 8000)) - 4000;
            az = int'($urandom_range(0, 8000)) - 4000;
         end else begin
            ax = int'($urandom_range(0, 32767)) - 16384;
            ay = int'($urandom_range(0, 32767)) - 16384;
            az = int'($urandom_range(0, 32767)) - 16384;
         end
         send_sample(ok, ax, ay, az, sensor_ms, n);
      end
   endtask

   // result side back-pressure in bursts, started at random while idle_on is set
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin : take_result
      event_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (event_words_due.size() == 0) begin
            errors++;
            $error("result word with no sample waiting for it");
         end else begin
            want = event_words_due.pop_front();
            ev_seen[want.ev]++;
            check_field("event_res", want.ev, rsp_tdata[2:0]);
            check_field("magnitude_sq", want.msq, rsp_tdata[32:3]);
            check_field("event_time_ms", want.stamp, rsp_tdata[64:33]);
            check_field("airborne_now", want.air, rsp_tdata[65]);
            check_field("last_impact_level", want.lvl, rsp_tdata[67:66]);
            check_field("hard_impact_count", want.hard, rsp_tdata[99:68]);
            check_field("strong_impact_count", want.heavy, rsp_tdata[131:100]);
            check_field("flight_time_ms", want.airtime, rsp_tdata[163:132]);
            check_field("last_of_run", want.last, rsp_tlast);
         end
      end
   end

   // stop a hung run: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d words still due",
                  WATCHDOG_LIMIT, event_words_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int n;
      sample_row_type r;
      // thresholds and state as they come out of reset
      thr_hard = HARD_IMPACT_RST;
      thr_mod = MODERATE_IMPACT_RST;
      thr_light = LIGHT_IMPACT_RST;
      thr_ff = FREEFALL_RST;
      hold_ms = FREEFALL_HOLD_RST;
      thr_land = LANDING_RST;
      m_airborne = 1'b0;
      m_lowg_on = 1'b0;
      m_flight_start = '0;
      m_lowg_start = '0;
      m_last_impact = '0;
      m_airtime = '0;
      m_level = LVL_NONE;
      m_hard = '0;
      m_strong = '0;
      foreach (ev_seen[i]) ev_seen[i] = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed samples on the reset thresholds
      for (int i = 0; i < NUM_ROWS; i++) begin
         r = DIRECTED_ROWS[i];
         send_sample(r.ok, r.x, r.y, r.z, r.stamp, n);
         if (r.typed)
            event_words_due[event_words_due.size() - n].ev = r.first_ev;
      end
      sensor_ms = DIRECTED_ROWS[NUM_ROWS-1].stamp;

      // random phases under several threshold settings
      wait_drained();
      load_thresholds(16'd4000, 16'd2500, 16'd1500, 16'd300, 16'd150, 16'd2000);
      random_samples(70);

      wait_drained();
      load_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_samples(60);

      // all ones: upper bits of the 14 bit thresholds are dropped
      wait_drained();
      load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_samples(60);

      wait_drained();
      load_thresholds(16'($urandom_range(0, 16000)), 16'($urandom_range(0, 16000)),
                      16'($urandom_range(0, 16000)), 16'($urandom_range(0, 16000)),
                      16'($urandom_range(0, 400)), 16'($urandom_range(0, 16000)));
      random_samples(80);

      wait_drained();
      load_thresholds(16'd1000, 16'd700, 16'd400, 16'd500, 16'd20, 16'd600);
      random_samples(80);

      // last phase at full rate on both sides
      wait_drained();
      idle_on = 1'b0;
      load_thresholds(16'd3000, 16'd2000, 16'd1200, 16'd400, 16'd60, 16'd1500);
      random_samples(80);

      wait_drained();
      $display("%0d samples under %0d threshold settings, %0d result words compared",
               samples_sent, settings_used, words_checked);
      $display("impacts %0d/%0d/%0d, freefalls %0d, landings %0d smooth %0d hard",
               ev_seen[EV_LIGHT], ev_seen[EV_MODERATE], ev_seen[EV_HARD],
               ev_seen[EV_FREEFALL], ev_seen[EV_LAND_SMOOTH], ev_seen[EV_LAND_HARD]);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
